// ----- rtl/core/tgl_pkg.sv -----
// Shared types and constants for the text glyph layout unit.
// Holds item structs, the configuration register map and the state codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tgl_pkg;

  localparam int CodeW     = 21;
  localparam int SlotW     = 7;
  localparam int PenW      = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  localparam logic [CodeW-1:0] SpaceCode   = 21'd32;
  localparam logic [7:0]       NewlineByte = 8'h0A;

  // request kinds
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqText = 1'b1;

  // configuration register map
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_CHAR_SPACING = 3'd2,
    CFG_SCALE        = 3'd3,
    CFG_GLYPH_WIDTH  = 3'd4,
    CFG_GLYPH_HEIGHT = 3'd5,
    CFG_SEARCH_LEN   = 3'd6
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } tgl_state_t;

  typedef struct packed {
    logic             req_type;
    logic             starts_text;
    logic [7:0]       text_byte;
    logic [SlotW-1:0] slot_index;
    logic [CodeW-1:0] slot_key;
  } tgl_in_t;

  typedef struct packed {
    logic [CodeW-1:0]      char_code;
    logic [SlotW-1:0]      glyph_slot;
    logic                  glyph_found;
    logic                  used_fallback;
    logic signed [PenW-1:0] draw_x;
    logic signed [PenW-1:0] draw_y;
  } tgl_out_t;

endpackage

`default_nettype wire

// ----- rtl/core/tgl_if.sv -----
// Valid/ready channel interfaces for the text glyph layout unit.
// Depends on tgl_pkg for the payload structs.
`timescale 1ns / 1ps
`default_nettype none

interface tgl_in_if import tgl_pkg::*; ();
  logic    valid;
  logic    ready;
  tgl_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tgl_out_if import tgl_pkg::*; ();
  logic     valid;
  logic     ready;
  tgl_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/text_glyph_layout_unit.sv -----
// A key load or a byte that completes no character leaves the unit idle and ready.
// A completed character scans the first L key slots for its code and the space code,
// L = min(search_len, GLYPH_SLOTS), with no scan when L is 0; the key memory is scanned
// one slot per cycle through its single read port. A new request transfers only after
// the result is loaded into the output register, which waits while the output stalls.
// Reset (rst_n low, synchronous) clears pen, partial character, state and output valid.
`timescale 1ns / 1ps
`default_nettype none

module text_glyph_layout_unit import tgl_pkg::*; #(
  parameter int GLYPH_SLOTS = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  tgl_in_if.sink                  in_ch,
  tgl_out_if.source               out_ch,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_idx,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  localparam int AW = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
  localparam int LW = $clog2(GLYPH_SLOTS + 1);

  // configuration registers
  logic [PenW-1:0]  origin_x_r, origin_y_r;
  logic [7:0]       char_spacing_r;
  logic [4:0]       scale_r;
  logic [5:0]       glyph_width_r, glyph_height_r;
  logic [7:0]       search_len_r;

  // layout state
  logic [PenW-1:0]  pen_x_r, pen_x_nxt;
  logic [PenW-1:0]  pen_y_r, pen_y_nxt;
  logic [CodeW-1:0] partial_r, partial_nxt;
  logic [1:0]       left_r, left_nxt;

  tgl_state_t       state_r, state_nxt;

  // key memory and scan
  logic [CodeW-1:0] key_mem [GLYPH_SLOTS];
  logic [CodeW-1:0] rd_data_r;
  logic [LW-1:0]    issue_idx_r;
  logic [AW-1:0]    cmp_idx_r;
  logic             cmp_valid_r;
  logic             rd_en;
  logic [LW-1:0]    limit;

  // character job
  logic [CodeW-1:0] job_code_r;
  logic [PenW-1:0]  job_x_r, job_y_r;
  logic             code_hit_r, space_hit_r;
  logic [AW-1:0]    code_slot_r, space_slot_r;

  // output register
  logic             out_valid_r;
  tgl_out_t         out_data_r;
  logic [AW-1:0]    out_slot_r;

  logic             in_acc;
  logic             load_out;
  logic             char_done;
  logic [CodeW-1:0] char_code;
  logic [PenW-1:0]  draw_x, draw_y;
  logic [PenW-1:0]  adv_x, adv_y;
  logic [PenW-1:0]  pen_x_base, pen_y_base;
  logic [CodeW-1:0] part_base, part_shift;
  logic [1:0]       left_base;
  logic             slot_ok;
  logic [AW-1:0]    wr_addr;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && (state_r == ST_IDLE);

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // search length and pen advances
  assign limit = (32'(search_len_r) < GLYPH_SLOTS) ? LW'(32'(search_len_r))
                                                   : LW'(GLYPH_SLOTS);
  assign adv_x = 16'({5'd0, glyph_width_r} * {6'd0, scale_r}) + 16'(char_spacing_r);
  assign adv_y = 16'({5'd0, glyph_height_r} * {6'd0, scale_r}) + 16'(char_spacing_r);

  assign slot_ok = (32'(in_ch.data.slot_index) < GLYPH_SLOTS);
  assign wr_addr = AW'(32'(in_ch.data.slot_index));

  // capture configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      char_spacing_r <= 8'd1;
      scale_r        <= 5'd1;
      glyph_width_r  <= 6'd8;
      glyph_height_r <= 6'd16;
      search_len_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ORIGIN_X:     origin_x_r     <= cfg_wdata;
        CFG_ORIGIN_Y:     origin_y_r     <= cfg_wdata;
        CFG_CHAR_SPACING: char_spacing_r <= cfg_wdata[7:0];
        CFG_SCALE:        scale_r        <= cfg_wdata[4:0];
        CFG_GLYPH_WIDTH:  glyph_width_r  <= cfg_wdata[5:0];
        CFG_GLYPH_HEIGHT: glyph_height_r <= cfg_wdata[5:0];
        CFG_SEARCH_LEN:   search_len_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // decode one request: text start, UTF-8 assembly, newline and pen moves
  always_comb begin
    pen_x_base = in_ch.data.starts_text ? origin_x_r : pen_x_r;
    pen_y_base = in_ch.data.starts_text ? origin_y_r : pen_y_r;
    part_base  = in_ch.data.starts_text ? '0 : partial_r;
    left_base  = in_ch.data.starts_text ? 2'd0 : left_r;
    part_shift = {part_base[CodeW-7:0], in_ch.data.text_byte[5:0]};

    pen_x_nxt   = pen_x_base;
    pen_y_nxt   = pen_y_base;
    partial_nxt = part_base;
    left_nxt    = left_base;
    char_done   = 1'b0;
    char_code   = '0;
    draw_x      = pen_x_base;
    draw_y      = pen_y_base;

    if (in_ch.data.req_type == ReqText) begin
      if (left_base != 2'd0) begin
        left_nxt = left_base - 2'd1;
        if (left_base == 2'd1) begin
          char_done   = 1'b1;
          char_code   = part_shift;
          partial_nxt = '0;
        end else begin
          partial_nxt = part_shift;
        end
      end else if (in_ch.data.text_byte == NewlineByte) begin
        pen_x_nxt = origin_x_r;
        pen_y_nxt = pen_y_base + adv_y;
      end else if (in_ch.data.text_byte[7] == 1'b0) begin
        char_done = 1'b1;
        char_code = CodeW'(in_ch.data.text_byte);
      end else if ((in_ch.data.text_byte & 8'hE0) == 8'hC0) begin
        partial_nxt = CodeW'(in_ch.data.text_byte & 8'h1F);
        left_nxt    = 2'd1;
      end else if ((in_ch.data.text_byte & 8'hF0) == 8'hE0) begin
        partial_nxt = CodeW'(in_ch.data.text_byte & 8'h0F);
        left_nxt    = 2'd2;
      end else if ((in_ch.data.text_byte & 8'hF8) == 8'hF0) begin
        partial_nxt = CodeW'(in_ch.data.text_byte & 8'h07);
        left_nxt    = 2'd3;
      end else begin
        char_done = 1'b1;
        char_code = '0;
      end
      if (char_done) begin
        pen_x_nxt = pen_x_base + adv_x;
      end
    end
  end

  // hold layout state between transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r   <= '0;
      pen_y_r   <= '0;
      partial_r <= '0;
      left_r    <= '0;
    end else if (in_acc) begin
      pen_x_r   <= pen_x_nxt;
      pen_y_r   <= pen_y_nxt;
      partial_r <= partial_nxt;
      left_r    <= left_nxt;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and scan controls
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    rd_en     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && char_done) begin
          state_nxt = (limit == '0) ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        rd_en = (issue_idx_r != limit);
        if (!rd_en && !cmp_valid_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // key memory: write on load, read one slot per scan cycle
  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.data.req_type == ReqLoad) && slot_ok) begin
      key_mem[wr_addr] <= in_ch.data.slot_key;
    end
    if (rd_en) begin
      rd_data_r <= key_mem[issue_idx_r[AW-1:0]];
    end
  end

  // scan address and compare stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_idx_r <= '0;
      cmp_valid_r <= 1'b0;
    end else begin
      cmp_valid_r <= rd_en;
      if (in_acc) begin
        issue_idx_r <= '0;
      end else if (rd_en) begin
        issue_idx_r <= issue_idx_r + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= issue_idx_r[AW-1:0];
  end

  // latch job and track lowest code and space matches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_hit_r  <= 1'b0;
      space_hit_r <= 1'b0;
    end else if (in_acc && char_done) begin
      code_hit_r  <= 1'b0;
      space_hit_r <= 1'b0;
    end else if (cmp_valid_r) begin
      if (!code_hit_r && (rd_data_r == job_code_r)) begin
        code_hit_r <= 1'b1;
      end
      if (!space_hit_r && (rd_data_r == SpaceCode)) begin
        space_hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && char_done) begin
      job_code_r <= char_code;
      job_x_r    <= draw_x;
      job_y_r    <= draw_y;
    end
    if (cmp_valid_r && !code_hit_r && (rd_data_r == job_code_r)) begin
      code_slot_r <= cmp_idx_r;
    end
    if (cmp_valid_r && !space_hit_r && (rd_data_r == SpaceCode)) begin
      space_slot_r <= cmp_idx_r;
    end
  end

  // output register: load on finish, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.char_code <= job_code_r;
      out_data_r.draw_x    <= job_x_r;
      out_data_r.draw_y    <= job_y_r;
      if (code_hit_r) begin
        out_slot_r               <= code_slot_r;
        out_data_r.glyph_slot    <= SlotW'(32'(code_slot_r));
        out_data_r.glyph_found   <= 1'b1;
        out_data_r.used_fallback <= 1'b0;
      end else if (space_hit_r) begin
        out_slot_r               <= space_slot_r;
        out_data_r.glyph_slot    <= SlotW'(32'(space_slot_r));
        out_data_r.glyph_found   <= 1'b1;
        out_data_r.used_fallback <= 1'b1;
      end else begin
        out_slot_r               <= '0;
        out_data_r.glyph_slot    <= '0;
        out_data_r.glyph_found   <= 1'b0;
        out_data_r.used_fallback <= 1'b0;
      end
    end
  end

  // checks
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result appeared outside finish state");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.glyph_found) |-> (LW'(out_slot_r) < limit))
    else $error("reported slot beyond searched range");

  a_fallback_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.used_fallback) |-> out_data_r.glyph_found)
    else $error("fallback flagged without a found slot");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_valid_r |-> (LW'(cmp_idx_r) < limit))
    else $error("compare stage past search limit");

endmodule

`default_nettype wire
